/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the row decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define LRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define LRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/lrd_pkg.sv */
// ----------------------------------------------------------------------------
// Row decoder package
// Field widths, limits, command bytes and the transaction structs of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

    // Field widths.
    localparam int CFG_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 13;
    localparam int BLANK_W = 12;

    // Count saturation and reset row width.
    localparam logic [RUN_W-1:0] COUNT_SAT     = 13'd4096;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd64;

    // Command bytes of the run-length body.
    localparam logic [BYTE_W-1:0] CH_DEAD    = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] CH_LIVE    = 8'h6F;  // 'o'
    localparam logic [BYTE_W-1:0] CH_ROW_END = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_PAT_END = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;  // '9'

    // One registered input byte.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_item;

    // One decoded run.
    typedef struct packed {
        logic               cell_alive;
        logic [RUN_W-1:0]   run_length;
        logic               row_end;
        logic [BLANK_W-1:0] blank_rows;
        logic               pattern_end;
    } t_result;

endpackage

`default_nettype wire

/* rtl/lrd_byte_if.sv */
// ----------------------------------------------------------------------------
// Byte channel interface
// Valid/ready channel that carries one byte of the encoded body.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrd_byte_if;
    import lrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/lrd_run_if.sv */
// ----------------------------------------------------------------------------
// Run channel interface
// Valid/ready channel that carries one decoded run.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrd_run_if;
    import lrd_pkg::*;

    logic               valid;
    logic               ready;
    logic               cell_alive;
    logic [RUN_W-1:0]   run_length;
    logic               row_end;
    logic [BLANK_W-1:0] blank_rows;
    logic               pattern_end;

    modport source (output valid, output cell_alive, output run_length, output row_end,
                    output blank_rows, output pattern_end, input ready);
    modport sink   (input valid, input cell_alive, input run_length, input row_end,
                    input blank_rows, input pattern_end, output ready);
endinterface

`default_nettype wire

/* rtl/lrd_in_stage.sv */
// ----------------------------------------------------------------------------
// Input register stage
// Holds one accepted byte until the decode engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lrd_pkg::BYTE_W-1:0] i_data,
    output logic                      o_ready,
    input  logic                      i_take,
    output lrd_pkg::t_in_item         o_item
);
    import lrd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              w_load;

    // The register is free when empty or when the engine takes its byte.
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;

endmodule

`default_nettype wire

/* rtl/lrd_engine.sv */
// ----------------------------------------------------------------------------
// Decode engine
// Builds the run count, tracks the column and registers one run per command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrd_engine #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lrd_pkg::CFG_W-1:0] i_row_width,
    input  lrd_pkg::t_in_item         i_item,
    output logic                      o_take,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output lrd_pkg::t_result          o_result
);
    import lrd_pkg::*;

    // Largest width the column logic can reach.
    localparam int WMAX_I = (MAX_WIDTH > ((1 << CFG_W) - 1)) ? ((1 << CFG_W) - 1) : MAX_WIDTH;
    localparam logic [CFG_W-1:0] WCLAMP = CFG_W'(WMAX_I);

    logic [RUN_W-1:0] r_run_count;
    logic             r_count_present;
    logic [CFG_W-1:0] r_column;
    logic             r_out_valid;
    t_result          r_result;

    logic [RUN_W-1:0] n_run_count;
    logic             n_count_present;
    logic [CFG_W-1:0] n_column;
    t_result          n_result;
    logic             w_emit;

    logic             w_digit;
    logic [RUN_W+3:0] w_prod;
    logic [CFG_W-1:0] w_width;
    logic [CFG_W-1:0] w_left;
    logic [RUN_W-1:0] w_req;
    logic [RUN_W-1:0] w_run;
    logic [BLANK_W-1:0] w_blanks;

    // A byte moves on whenever the result register can take a new run.
    assign o_take = i_item.valid && (!r_out_valid || i_out_ready);

    // Effective width and the columns left in the current row.
    always_comb begin
        if (i_row_width == '0) begin
            w_width = CFG_W'(1);
        end else if (i_row_width > WCLAMP) begin
            w_width = WCLAMP;
        end else begin
            w_width = i_row_width;
        end
        w_left = (r_column >= w_width) ? '0 : (w_width - r_column);
    end

    // Count times ten plus the new digit, by shift and add.
    assign w_digit = (i_item.data >= CH_ZERO) && (i_item.data <= CH_NINE);
    assign w_prod  = ({4'b0, r_run_count} << 3) + ({4'b0, r_run_count} << 1)
                   + {{(RUN_W){1'b0}}, i_item.data[3:0]};

    // Requested run length, clipped to the row.
    assign w_req = r_count_present ? r_run_count : RUN_W'(1);
    assign w_run = (w_req > w_left) ? w_left : w_req;

    // Blank rows from a count before the row terminator.
    assign w_blanks = (r_count_present && (r_run_count > RUN_W'(1)))
                    ? BLANK_W'(r_run_count - RUN_W'(1)) : '0;

    // Command decode and next state.
    always_comb begin
        n_run_count          = r_run_count;
        n_count_present      = r_count_present;
        n_column             = r_column;
        w_emit               = 1'b0;
        n_result.cell_alive  = 1'b0;
        n_result.run_length  = w_left;
        n_result.row_end     = 1'b1;
        n_result.blank_rows  = '0;
        n_result.pattern_end = 1'b0;
        case (i_item.data)
            CH_DEAD, CH_LIVE: begin
                w_emit              = 1'b1;
                n_result.cell_alive = (i_item.data == CH_LIVE);
                n_result.run_length = w_run;
                n_result.row_end    = 1'b0;
                n_column            = r_column + w_run;
                n_run_count         = '0;
                n_count_present     = 1'b0;
            end
            CH_ROW_END: begin
                w_emit              = 1'b1;
                n_result.blank_rows = w_blanks;
                n_column            = '0;
                n_run_count         = '0;
                n_count_present     = 1'b0;
            end
            CH_PAT_END: begin
                w_emit               = 1'b1;
                n_result.pattern_end = 1'b1;
                n_column             = '0;
                n_run_count          = '0;
                n_count_present      = 1'b0;
            end
            default: begin
                if (w_digit) begin
                    n_run_count     = (w_prod > (RUN_W + 4)'(COUNT_SAT))
                                    ? COUNT_SAT : w_prod[RUN_W-1:0];
                    n_count_present = 1'b1;
                end
            end
        endcase
    end

    // Decoder state advances on each byte the engine takes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count     <= '0;
            r_count_present <= 1'b0;
            r_column        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_take) begin
                r_run_count     <= n_run_count;
                r_count_present <= n_count_present;
                r_column        <= n_column;
            end
            if (o_take) begin
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `LRD_ASSERT(a_count_sat, i_clk, i_rst_n, r_run_count <= COUNT_SAT, "run count over limit")
    `LRD_ASSERT_IMPL(a_count_clear, i_clk, i_rst_n, !r_count_present, r_run_count == '0, "stale count")
    `LRD_ASSERT_IMPL(a_pend_row, i_clk, i_rst_n, r_out_valid && r_result.pattern_end, r_result.row_end, "pattern end without row end")
    `LRD_ASSERT_IMPL(a_blank_row, i_clk, i_rst_n, r_out_valid && (r_result.blank_rows != '0), r_result.row_end, "blank rows without row end")
    `LRD_ASSERT(a_col_reset, i_clk, i_rst_n, (o_take && w_emit && n_result.row_end) |=> (r_column == '0), "column not cleared at row end")

endmodule

`default_nettype wire

/* rtl/life_rle_row_decoder.sv */
// ----------------------------------------------------------------------------
// Run-length pattern row decoder
// A byte is held in the input byte register, then its run in the engine's result register.
// Throughput: one byte per cycle while the run channel is not stalled.
// Reset: synchronous active-low; clears count and column, row width to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rle_row_decoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lrd_pkg::CFG_W-1:0] i_cfg_wdata,
    lrd_byte_if.sink                  i_byte_ch,
    lrd_run_if.source                 o_run_ch
);
    import lrd_pkg::*;

    logic [CFG_W-1:0] r_row_width;
    t_in_item         w_item;
    logic             w_take;
    logic             w_out_valid;
    t_result          w_result;

    // Row width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    // Input byte register.
    lrd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte_ch.valid),
        .i_data  (i_byte_ch.in_byte),
        .o_ready (i_byte_ch.ready),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // Decode and result register.
    lrd_engine #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_width (r_row_width),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_out_ready (o_run_ch.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    // Result transaction.
    assign o_run_ch.valid       = w_out_valid;
    assign o_run_ch.cell_alive  = w_result.cell_alive;
    assign o_run_ch.run_length  = w_result.run_length;
    assign o_run_ch.row_end     = w_result.row_end;
    assign o_run_ch.blank_rows  = w_result.blank_rows;
    assign o_run_ch.pattern_end = w_result.pattern_end;

endmodule

`default_nettype wire

/* bench/life_rle_row_decoder_test.sv */
// ----------------------------------------------------------------------------
// Row decoder testbench
// Drives run-length body bytes into the decoder under random bursts and
// output stalls. Each decoded run is compared field by field against the runs
// predicted from the accepted bytes and the row width in force.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rle_row_decoder_test;
    import lrd_pkg::*;

    localparam int ROW_MAX       = 4096;
    localparam int BLANK_MAX     = 4095;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_SYMBOLS = 160;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    lrd_byte_if byte_ch ();
    lrd_run_if  run_ch ();

    life_rle_row_decoder #(
        .MAX_WIDTH(ROW_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_byte_ch  (byte_ch),
        .o_run_ch   (run_ch)
    );

    always #6 i_clk = ~i_clk;

    // Predicted decoder state and the runs still owed by the block.
    logic [CFG_W-1:0] row_width_set = ROW_WIDTH_RST;
    int               pending_count = 0;
    bit               count_seen    = 1'b0;
    int               column_pos    = 0;
    t_result          expected_runs[$];

    int errors       = 0;
    int symbols_sent = 0;
    int burst_left   = 0;
    int stall_left   = 0;
    logic [7:0] stall_phase = '0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Row width after clamping to the supported range.
    function automatic int cells_per_row();
        int w;
        w = int'(row_width_set);
        if (w < 1) w = 1;
        if (w > ROW_MAX) w = ROW_MAX;
        return w;
    endfunction

    // Advances the predicted state by one byte and queues the run it causes.
    // Returns 1 when the byte is a digit or a command.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b);
        t_result run;
        int      left;
        int      n;
        left = (column_pos >= cells_per_row()) ? 0 : cells_per_row() - column_pos;
        run  = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            n = pending_count * 10 + int'(b - CH_ZERO);
            pending_count = (n > int'(COUNT_SAT)) ? int'(COUNT_SAT) : n;
            count_seen    = 1'b1;
            return 1'b1;
        end
        if (b == CH_DEAD || b == CH_LIVE) begin
            n = count_seen ? pending_count : 1;
            if (n > left) n = left;
            column_pos += n;
            run.cell_alive = (b == CH_LIVE);
            run.run_length = RUN_W'(n);
        end else if (b == CH_ROW_END || b == CH_PAT_END) begin
            n = 0;
            if (b == CH_ROW_END && count_seen && pending_count > 1) begin
                n = pending_count - 1;
                if (n > BLANK_MAX) n = BLANK_MAX;
            end
            run.run_length  = RUN_W'(left);
            run.row_end     = 1'b1;
            run.blank_rows  = BLANK_W'(n);
            run.pattern_end = (b == CH_PAT_END);
            column_pos      = 0;
        end else begin
            return 1'b0;
        end
        pending_count = 0;
        count_seen    = 1'b0;
        expected_runs.insert(expected_runs.size(), run);
        return 1'b1;
    endfunction

    // Sends one byte and waits for its transaction; ends bursts with a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        if (decode_byte(b)) symbols_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Sends a decimal count, now and then with a leading zero.
    task automatic send_number(input int lo, input int hi);
        if ($urandom_range(0, 9) == 0) send_byte(CH_ZERO);
        send_text($sformatf("%0d", $urandom_range(lo, hi)));
    endtask

    // Holds the input until every predicted run has come out and the block
    // has had time to absorb any trailing digits.
    task automatic wait_for_runs();
        if (byte_ch.valid) byte_ch.valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_row_width(input logic [CFG_W-1:0] v);
        wait_for_runs();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        row_width_set = v;
    endtask

    // Output side: check each run transaction, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && run_ch.valid === 1'b1 && run_ch.ready === 1'b1) check_run();
        stall_phase = stall_phase + 1'b1;
        if (stall_left > 0) begin
            run_ch.ready <= 1'b0;
            stall_left--;
        end else if (stall_phase[7] && $urandom_range(0, 3) == 0) begin
            run_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            run_ch.ready <= 1'b1;
        end
    end

    task automatic check_run();
        t_result want;
        if (expected_runs.size() == 0) begin
            report_error("run transaction with no byte waiting for it");
            return;
        end
        want = expected_runs.pop_front();
        if (run_ch.cell_alive !== want.cell_alive)
            report_error($sformatf("cell_alive %b, expected %b",
                                   run_ch.cell_alive, want.cell_alive));
        if (run_ch.run_length !== want.run_length)
            report_error($sformatf("run_length %0d, expected %0d",
                                   run_ch.run_length, want.run_length));
        if (run_ch.row_end !== want.row_end)
            report_error($sformatf("row_end %b, expected %b", run_ch.row_end, want.row_end));
        if (run_ch.blank_rows !== want.blank_rows)
            report_error($sformatf("blank_rows %0d, expected %0d",
                                   run_ch.blank_rows, want.blank_rows));
        if (run_ch.pattern_end !== want.pattern_end)
            report_error($sformatf("pattern_end %b, expected %b",
                                   run_ch.pattern_end, want.pattern_end));
    endtask

    // Every command at the reset width of 64, with empty, zero and
    // saturated counts, clipping, and bytes that must be skipped.
    task automatic test_commands();
        send_text("o");
        send_text("0b3o");
        send_byte(8'hFF);
        send_text("2$");
        send_text("70o");
        send_text("b");
        send_text("4097$");
        send_text("5!");
        send_byte(8'h00);
        send_text("1$");
    endtask

    // Widths past both ends of the range, and a width cut mid-row.
    task automatic test_width_limits();
        write_row_width('0);
        send_text("2o!");
        write_row_width('1);
        send_text("9999o$");
        write_row_width(13'd64);
        send_text("50o");
        write_row_width(13'd20);
        send_text("o$");
    endtask

    // Mostly well-formed rows with random counts, plus noise and broken
    // counts, over a series of row widths.
    task automatic test_random_streams();
        int target;
        int pick;
        int n;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_row_width(13'd1);
                1: write_row_width(13'd16);
                2: write_row_width(13'd64);
                3: write_row_width(CFG_W'($urandom_range(2, 100)));
                4: write_row_width(13'd4096);
                5: write_row_width('0);
                6: write_row_width('1);
                default: write_row_width(CFG_W'($urandom_range(100, 4095)));
            endcase
            target = symbols_sent + PHASE_SYMBOLS;
            while (symbols_sent < target) begin
                pick = $urandom_range(0, 99);
                n    = $urandom_range(0, 9);
                if (pick < 55) begin
                    if (n >= 1 && n < 3) send_number(0, 3);
                    else if (n >= 3 && n < 9) send_number(0, cells_per_row());
                    else if (n == 9) send_number(4000, 99999);
                    send_byte($urandom_range(0, 1) ? CH_LIVE : CH_DEAD);
                end else if (pick < 72) begin
                    if (n == 3) send_number(0, 1);
                    else if (n >= 4 && n < 7) send_number(2, 9);
                    else if (n == 7) send_number(10, 500);
                    else if (n >= 8) send_number(4000, 99999);
                    send_byte(CH_ROW_END);
                end else if (pick < 78) begin
                    if (n < 3) send_number(0, 99);
                    send_byte(CH_PAT_END);
                end else if (pick < 90) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end else begin
                    send_number(0, 99);
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                    send_number(0, 99);
                    send_byte($urandom_range(0, 1) ? CH_ROW_END : CH_DEAD);
                end
            end
        end
    endtask

    initial begin
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_commands();
        test_width_limits();
        test_random_streams();
        wait_for_runs();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("life_rle_row_decoder_test OK");
        end else begin
            $display("life_rle_row_decoder_test NOT OK");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #5000000;
        $display("life_rle_row_decoder_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* life_rle_row_decoder.f */
+incdir+rtl
rtl/lrd_pkg.sv
rtl/lrd_byte_if.sv
rtl/lrd_run_if.sv
rtl/lrd_in_stage.sv
rtl/lrd_engine.sv
rtl/life_rle_row_decoder.sv
bench/life_rle_row_decoder_test.sv
